[rtl/core/inikv_pkg.sv]
// ----------------------------------------------------------------------------
// inikv_pkg
// Types and constants shared by the key=value line parser modules.
// ----------------------------------------------------------------------------
package inikv_pkg;

   typedef struct packed {
      logic       kind;
      logic [7:0] byte_req;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] part;
      logic [2:0] status;
      logic       last;
   } rsp_type;

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_EOL  = 1'b1;

   localparam logic [1:0] PART_KEY = 2'd0;
   localparam logic [1:0] PART_VAL = 2'd1;
   localparam logic [1:0] PART_ERR = 2'd2;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOSEP     = 3'd1;
   localparam logic [2:0] ST_EMPTY_KEY = 3'd2;
   localparam logic [2:0] ST_EMPTY_VAL = 3'd3;
   localparam logic [2:0] ST_TOO_LONG  = 3'd4;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_EQUAL = 8'h3D;

   typedef enum logic [5:0] {
      PH_SKIP_KEY = 6'b000001,
      PH_KEY      = 6'b000010,
      PH_SKIP_VAL = 6'b000100,
      PH_VAL      = 6'b001000,
      PH_DONE     = 6'b010000,
      PH_NOSEP    = 6'b100000
   } phase_type;

   typedef enum logic [2:0] {
      CS_IDLE = 3'b001,
      CS_KEY  = 3'b010,
      CS_VAL  = 3'b100
   } ctrl_state_type;

   typedef struct packed {
      logic byte_en;
      logic eol_err;
      logic rd_key;
      logic rd_val;
      logic rd_wrap;
      logic line_clear;
   } cmd_type;

   typedef struct packed {
      logic eol_ok;
      logic key_end;
      logic val_end;
   } sts_type;

endpackage

[rtl/core/ini_key_value_line_parser_unit.sv]
// ----------------------------------------------------------------------------
// ini_key_value_line_parser_unit
// Parses one text line into a key=value pair and reports it at line end.
// ----------------------------------------------------------------------------
//  channel   ports                          handshake
//  request   start, busy, req_data          taken when start & !busy
//  response  rsp_strobe, rsp_data           single-cycle strobe per item, no stall
//
//  Line bytes may follow back to back while busy is low.
//  An end-of-line item with an error gives one item on the next cycle.
//  A valid line streams key then value bytes, one per cycle through the
//  single read port of each byte store: the state register enters CS_KEY,
//  then the read and strobe registers give each byte; busy stays high
//  until the last value byte is read. Reset is synchronous; the stores are not cleared and need no pass.
// ----------------------------------------------------------------------------
module ini_key_value_line_parser_unit
   import inikv_pkg::*;
#(
   parameter int KEY_MAX   = 32,
   parameter int VALUE_MAX = 32
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;

   inikv_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .kind  (req_data.kind),
      .sts   (sts),
      .busy  (busy),
      .cmd   (cmd)
   );

   inikv_dp #(
      .KEY_MAX   (KEY_MAX),
      .VALUE_MAX (VALUE_MAX)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .byte_req   (req_data.byte_req),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

[rtl/core/inikv_ctrl.sv]
// ----------------------------------------------------------------------------
// inikv_ctrl
// Controller: takes items, sequences the key and value read-out at line end.
// ----------------------------------------------------------------------------
module inikv_ctrl
   import inikv_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    kind,
   input  sts_type sts,
   output logic    busy,
   output cmd_type cmd
);

   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         CS_IDLE: begin
            busy = 1'b0;
            if (start) begin
               if (kind == KIND_BYTE) begin
                  cmd.byte_en = 1'b1;
               end else if (sts.eol_ok) begin
                  state_in = CS_KEY;
               end else begin
                  cmd.eol_err    = 1'b1;
                  cmd.line_clear = 1'b1;
               end
            end
         end
         CS_KEY: begin
            cmd.rd_key = 1'b1;
            if (sts.key_end) begin
               cmd.rd_wrap = 1'b1;
               state_in    = CS_VAL;
            end
         end
         CS_VAL: begin
            cmd.rd_val = 1'b1;
            if (sts.val_end) begin
               cmd.rd_wrap    = 1'b1;
               cmd.line_clear = 1'b1;
               state_in       = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/core/inikv_dp.sv]
// ----------------------------------------------------------------------------
// inikv_dp
// Datapath: line scan, key and value stores, counters and result register.
// ----------------------------------------------------------------------------
module inikv_dp
   import inikv_pkg::*;
#(
   parameter int KEY_MAX   = 32,
   parameter int VALUE_MAX = 32
)
(
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   input  logic [7:0] byte_req,
   output sts_type    sts,
   output logic       rsp_strobe,
   output rsp_type    rsp_data
);

   localparam int KCW  = $clog2(KEY_MAX + 1);
   localparam int VCW  = $clog2(VALUE_MAX + 1);
   localparam int KIW  = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
   localparam int VIW  = (VALUE_MAX > 1) ? $clog2(VALUE_MAX) : 1;
   localparam int RW   = (KCW > VCW) ? KCW : VCW;

   logic [7:0] key_mem [KEY_MAX];
   logic [7:0] val_mem [VALUE_MAX];

   phase_type      phase_ff, phase_in;
   logic [KCW-1:0] key_cnt_ff, key_cnt_in;
   logic [KCW-1:0] key_trim_ff, key_trim_in;
   logic [VCW-1:0] val_cnt_ff, val_cnt_in;
   logic [VCW-1:0] val_trim_ff, val_trim_in;
   logic           too_long_ff, too_long_in;
   logic [RW-1:0]  rd_idx_ff, rd_idx_in;
   logic           key_wr, val_wr;

   logic [7:0] key_rd_ff, val_rd_ff;
   logic       strobe_ff;
   logic [1:0] part_ff;
   logic [2:0] status_ff;
   logic       last_ff;

   logic          is_blank, is_equal, is_end;
   logic [2:0]    eol_status;
   logic [RW-1:0] key_trim_rw, val_trim_rw;

   assign is_blank = (byte_req == CH_SPACE) || (byte_req == CH_TAB) ||
                     (byte_req == CH_CR) || (byte_req == CH_LF);
   assign is_equal = (byte_req == CH_EQUAL);
   assign is_end   = (byte_req == CH_NUL) || is_equal ||
                     (byte_req == CH_SEMI) || (byte_req == CH_HASH);

   always_comb begin
      priority if (phase_ff == PH_SKIP_KEY || phase_ff == PH_KEY ||
                   phase_ff == PH_NOSEP) begin
         eol_status = ST_NOSEP;
      end else if (key_trim_ff == '0) begin
         eol_status = ST_EMPTY_KEY;
      end else if (val_trim_ff == '0) begin
         eol_status = ST_EMPTY_VAL;
      end else if (too_long_ff) begin
         eol_status = ST_TOO_LONG;
      end else begin
         eol_status = ST_OK;
      end
   end

   assign key_trim_rw = RW'(key_trim_ff);
   assign val_trim_rw = RW'(val_trim_ff);

   assign sts.eol_ok  = (eol_status == ST_OK);
   assign sts.key_end = (rd_idx_ff == key_trim_rw - RW'(1));
   assign sts.val_end = (rd_idx_ff == val_trim_rw - RW'(1));

   always_comb begin
      phase_in    = phase_ff;
      key_cnt_in  = key_cnt_ff;
      key_trim_in = key_trim_ff;
      val_cnt_in  = val_cnt_ff;
      val_trim_in = val_trim_ff;
      too_long_in = too_long_ff;
      key_wr      = 1'b0;
      val_wr      = 1'b0;
      if (cmd.line_clear) begin
         phase_in    = PH_SKIP_KEY;
         key_cnt_in  = '0;
         key_trim_in = '0;
         val_cnt_in  = '0;
         val_trim_in = '0;
         too_long_in = 1'b0;
      end else if (cmd.byte_en) begin
         unique case (phase_ff)
            PH_SKIP_KEY, PH_KEY: begin
               if (phase_ff == PH_SKIP_KEY && is_blank) begin
                  phase_in = PH_SKIP_KEY;
               end else if (is_equal) begin
                  phase_in = PH_SKIP_VAL;
               end else if (is_end) begin
                  phase_in = PH_NOSEP;
               end else begin
                  phase_in = PH_KEY;
                  if (key_cnt_ff == KCW'(KEY_MAX)) begin
                     too_long_in = too_long_ff | ~is_blank;
                  end else begin
                     key_wr     = 1'b1;
                     key_cnt_in = key_cnt_ff + KCW'(1);
                     if (!is_blank) begin
                        key_trim_in = key_cnt_ff + KCW'(1);
                     end
                  end
               end
            end
            PH_SKIP_VAL, PH_VAL: begin
               if (phase_ff == PH_SKIP_VAL && is_blank) begin
                  phase_in = PH_SKIP_VAL;
               end else if (is_end) begin
                  phase_in = PH_DONE;
               end else begin
                  phase_in = PH_VAL;
                  if (val_cnt_ff == VCW'(VALUE_MAX)) begin
                     too_long_in = too_long_ff | ~is_blank;
                  end else begin
                     val_wr     = 1'b1;
                     val_cnt_in = val_cnt_ff + VCW'(1);
                     if (!is_blank) begin
                        val_trim_in = val_cnt_ff + VCW'(1);
                     end
                  end
               end
            end
            PH_DONE, PH_NOSEP: begin
               phase_in = phase_ff;
            end
            default: begin
               phase_in = PH_SKIP_KEY;
            end
         endcase
      end
   end

   always_comb begin
      rd_idx_in = rd_idx_ff;
      if (cmd.rd_wrap) begin
         rd_idx_in = '0;
      end else if (cmd.rd_key || cmd.rd_val) begin
         rd_idx_in = rd_idx_ff + RW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_SKIP_KEY;
         key_cnt_ff  <= '0;
         key_trim_ff <= '0;
         val_cnt_ff  <= '0;
         val_trim_ff <= '0;
         too_long_ff <= 1'b0;
         rd_idx_ff   <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         key_cnt_ff  <= key_cnt_in;
         key_trim_ff <= key_trim_in;
         val_cnt_ff  <= val_cnt_in;
         val_trim_ff <= val_trim_in;
         too_long_ff <= too_long_in;
         rd_idx_ff   <= rd_idx_in;
         strobe_ff   <= cmd.eol_err | cmd.rd_key | cmd.rd_val;
      end
   end

   always_ff @(posedge clock) begin
      if (key_wr) begin
         key_mem[key_cnt_ff[KIW-1:0]] <= byte_req;
      end
      if (cmd.rd_key) begin
         key_rd_ff <= key_mem[rd_idx_ff[KIW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (val_wr) begin
         val_mem[val_cnt_ff[VIW-1:0]] <= byte_req;
      end
      if (cmd.rd_val) begin
         val_rd_ff <= val_mem[rd_idx_ff[VIW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eol_err) begin
         part_ff   <= PART_ERR;
         status_ff <= eol_status;
         last_ff   <= 1'b1;
      end else if (cmd.rd_key) begin
         part_ff   <= PART_KEY;
         status_ff <= ST_OK;
         last_ff   <= 1'b0;
      end else if (cmd.rd_val) begin
         part_ff   <= PART_VAL;
         status_ff <= ST_OK;
         last_ff   <= sts.val_end;
      end
   end

   always_comb begin
      rsp_data.part   = part_ff;
      rsp_data.status = status_ff;
      rsp_data.last   = last_ff;
      unique case (part_ff)
         PART_KEY: rsp_data.out_byte = key_rd_ff;
         PART_VAL: rsp_data.out_byte = val_rd_ff;
         default:  rsp_data.out_byte = 8'h00;
      endcase
   end

   assign rsp_strobe = strobe_ff;

endmodule

[dv/ini_key_value_line_parser_unit_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ini_key_value_line_parser_unit_checker
// Watches the request and response channels of the key=value line parser,
// keeps its own parse of each line and compares every response item, field
// by field, with the oldest one it expects.
// ----------------------------------------------------------------------------
module ini_key_value_line_parser_unit_checker
   import inikv_pkg::*;
#(
   parameter int KEY_MAX   = 32,
   parameter int VALUE_MAX = 32
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_strobe,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending
);

   localparam int KEY_SIDE = 0;
   localparam int VAL_SIDE = 1;

   logic [7:0] text_store [2][256];
   int         held [2];
   int         kept [2];
   logic       overflow;
   phase_type  parse_phase;
   rsp_type    line_results [$];
   int         mismatches = 0;
   int         queued = 0;

   assign fail_count = mismatches;
   assign pending    = queued;

   function automatic logic is_blank(input logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
   endfunction

   function automatic logic is_stop(input logic [7:0] c);
      return c == CH_NUL || c == CH_EQUAL || c == CH_SEMI || c == CH_HASH;
   endfunction

   task automatic clear_line();
      parse_phase = PH_SKIP_KEY;
      held        = '{0, 0};
      kept        = '{0, 0};
      overflow    = 1'b0;
   endtask

   task automatic take_char(input int side, input logic [7:0] c);
      int depth;
      depth = (side == KEY_SIDE) ? KEY_MAX : VALUE_MAX;
      if (held[side] >= depth) begin
         if (!is_blank(c)) overflow = 1'b1;
      end else begin
         text_store[side][held[side]] = c;
         held[side]++;
         if (!is_blank(c)) kept[side] = held[side];
      end
   endtask

   task automatic report_line();
      logic [2:0] status;
      rsp_type    item;
      status = ST_OK;
      if (parse_phase == PH_SKIP_KEY || parse_phase == PH_KEY || parse_phase == PH_NOSEP)
         status = ST_NOSEP;
      else if (kept[KEY_SIDE] == 0)
         status = ST_EMPTY_KEY;
      else if (kept[VAL_SIDE] == 0)
         status = ST_EMPTY_VAL;
      else if (overflow)
         status = ST_TOO_LONG;
      if (status != ST_OK) begin
         item = '{out_byte: 8'h00, part: PART_ERR, status: status, last: 1'b1};
         line_results.push_back(item);
      end else begin
         for (int i = 0; i < kept[KEY_SIDE]; i++) begin
            item = '{out_byte: text_store[KEY_SIDE][i], part: PART_KEY, status: ST_OK,
                     last: 1'b0};
            line_results.push_back(item);
         end
         for (int i = 0; i < kept[VAL_SIDE]; i++) begin
            item = '{out_byte: text_store[VAL_SIDE][i], part: PART_VAL, status: ST_OK,
                     last: (i + 1 == kept[VAL_SIDE])};
            line_results.push_back(item);
         end
      end
      clear_line();
   endtask

   task automatic parse_item(input req_type item);
      logic [7:0] c;
      c = item.byte_req;
      if (item.kind == KIND_EOL) begin
         report_line();
      end else begin
         case (parse_phase)
            PH_SKIP_KEY, PH_KEY: begin
               if (!(parse_phase == PH_SKIP_KEY && is_blank(c))) begin
                  if (c == CH_EQUAL) parse_phase = PH_SKIP_VAL;
                  else if (is_stop(c)) parse_phase = PH_NOSEP;
                  else begin
                     parse_phase = PH_KEY;
                     take_char(KEY_SIDE, c);
                  end
               end
            end
            PH_SKIP_VAL, PH_VAL: begin
               if (!(parse_phase == PH_SKIP_VAL && is_blank(c))) begin
                  if (is_stop(c)) parse_phase = PH_DONE;
                  else begin
                     parse_phase = PH_VAL;
                     take_char(VAL_SIDE, c);
                  end
               end
            end
            default: ;
         endcase
      end
   endtask

   task automatic compare_field(input string field, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0h, actual %0h", field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_line();
         line_results.delete();
      end else begin
         if (rsp_strobe) begin
            if (line_results.size() == 0) begin
               $error("unexpected response item: out_byte %0h part %0h status %0h last %0h",
                      rsp_data.out_byte, rsp_data.part, rsp_data.status, rsp_data.last);
               mismatches++;
            end else begin
               want = line_results.pop_front();
               compare_field("out_byte", 32'(want.out_byte), 32'(rsp_data.out_byte));
               compare_field("part", 32'(want.part), 32'(rsp_data.part));
               compare_field("status", 32'(want.status), 32'(rsp_data.status));
               compare_field("last", 32'(want.last), 32'(rsp_data.last));
            end
         end
         if (start && !busy) parse_item(req_data);
      end
      queued <= line_results.size();
   end

endmodule

[dv/ini_key_value_line_parser_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ini_key_value_line_parser_unit_tb
// Feeds text lines into the key=value line parser in random bursts: a few
// hand-made lines for the edge cases, then mostly well-formed lines with
// random content mixed with broken lines and noise. A checker beside the
// block predicts and compares every response item.
// ----------------------------------------------------------------------------
module ini_key_value_line_parser_unit_tb;
   import inikv_pkg::*;

   localparam int KEY_MAX      = 32;
   localparam int VALUE_MAX    = 32;
   localparam int ITEM_TARGET  = 300;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 80;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   req_type    req_data = '0;
   logic       busy;
   logic       rsp_strobe;
   rsp_type    rsp_data;
   int         fail_count;
   int         pending;
   int         idle_cycles = 0;
   int         burst_left = 0;
   logic [7:0] line_bytes [$];
   logic [7:0] blank_chars [4] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};
   logic [7:0] stop_chars [4]  = '{CH_EQUAL, CH_SEMI, CH_HASH, CH_NUL};

   ini_key_value_line_parser_unit #(
      .KEY_MAX   (KEY_MAX),
      .VALUE_MAX (VALUE_MAX)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   ini_key_value_line_parser_unit_checker #(
      .KEY_MAX   (KEY_MAX),
      .VALUE_MAX (VALUE_MAX)
   ) line_checker (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("[ini_key_value_line_parser_unit] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_item(input logic kind, input logic [7:0] value);
      int gap;
      req_data <= '{kind: kind, byte_req: value};
      start    <= 1'b1;
      @(negedge clock);
      while (busy) begin
         @(posedge clock);
         @(negedge clock);
      end
      @(posedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 24);
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(KIND_BYTE, s[i]);
   endtask

   task automatic send_eol();
      send_item(KIND_EOL, 8'($urandom_range(0, 255)));
   endtask

   task automatic push_blanks(input int n);
      repeat (n) line_bytes.push_back(blank_chars[$urandom_range(0, 3)]);
   endtask

   task automatic push_word(input int n);
      logic [7:0] c;
      for (int i = 0; i < n; i++) begin
         if (i > 0 && i < n - 1 && $urandom_range(0, 5) == 0) begin
            push_blanks(1);
         end else begin
            c = 8'($urandom_range(1, 255));
            if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF ||
                c == CH_EQUAL || c == CH_SEMI || c == CH_HASH)
               c = c | 8'h80;
            line_bytes.push_back(c);
         end
      end
   endtask

   task automatic send_line();
      foreach (line_bytes[i]) send_item(KIND_BYTE, line_bytes[i]);
      send_eol();
      line_bytes.delete();
   endtask

   initial begin
      int items_sent;
      int line_no;
      int shape;
      int klen;
      int vlen;
      int tail;
      items_sent = 0;
      line_no    = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_text("a=b");
      send_eol();
      send_item(KIND_BYTE, 8'hFF);
      send_item(KIND_BYTE, CH_EQUAL);
      send_item(KIND_BYTE, 8'h01);
      send_item(KIND_EOL, 8'hFF);
      send_item(KIND_BYTE, CH_TAB);
      send_item(KIND_BYTE, CH_CR);
      send_text(" k x=");
      send_item(KIND_BYTE, CH_LF);
      send_text("v w;");
      send_eol();
      send_text("=v");
      send_eol();
      send_text("k=#");
      send_eol();
      send_text("k;v");
      send_eol();
      send_text("k");
      send_item(KIND_EOL, 8'h00);
      send_text("k");
      send_item(KIND_BYTE, CH_NUL);
      send_eol();

      // mostly well-formed lines; the first three hit the buffer limits
      while (items_sent < ITEM_TARGET) begin
         shape = $urandom_range(0, 99);
         klen  = ($urandom_range(0, 19) == 0) ? $urandom_range(29, KEY_MAX)
                                               : $urandom_range(1, 8);
         vlen  = ($urandom_range(0, 19) == 0) ? $urandom_range(29, VALUE_MAX)
                                               : $urandom_range(1, 8);
         tail  = 0;
         if (line_no == 0) begin
            shape = 0;
            klen  = KEY_MAX;
            vlen  = VALUE_MAX;
         end else if (line_no == 1) begin
            shape = 65;
            klen  = KEY_MAX + 1;
         end else if (line_no == 2) begin
            shape = 65;
            vlen  = VALUE_MAX + 1;
         end else if (shape >= 65 && shape < 72) begin
            if ($urandom_range(0, 1)) klen = $urandom_range(KEY_MAX + 1, KEY_MAX + 4);
            else vlen = $urandom_range(VALUE_MAX + 1, VALUE_MAX + 4);
         end
         if (shape >= 90) begin
            repeat ($urandom_range(0, 12)) line_bytes.push_back(8'($urandom_range(0, 255)));
         end else begin
            push_blanks($urandom_range(0, 2));
            if (!(shape >= 72 && shape < 78)) begin
               push_word(klen);
               push_blanks($urandom_range(0, 2));
            end
            if (shape >= 84) begin
               if ($urandom_range(0, 1)) line_bytes.push_back(stop_chars[$urandom_range(1, 3)]);
            end else begin
               line_bytes.push_back(CH_EQUAL);
               push_blanks($urandom_range(0, 2));
               if (!(shape >= 78 && shape < 84)) begin
                  push_word(vlen);
                  push_blanks($urandom_range(0, 2));
               end
               if ($urandom_range(0, 1)) begin
                  line_bytes.push_back(stop_chars[$urandom_range(0, 3)]);
                  tail = $urandom_range(0, 4);
                  repeat (tail) line_bytes.push_back(8'($urandom_range(0, 255)));
               end
            end
         end
         items_sent += line_bytes.size() + 1;
         line_no++;
         send_line();
      end

      start <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ini_key_value_line_parser_unit] OK");
      end else begin
         $display("[ini_key_value_line_parser_unit] ERROR");
      end
      $finish;
   end

endmodule
